>>> rtl/sil_pkg.sv
// sil_pkg: shared types and constants for the sorted insert list.
// Table depth, op and status codes, and the command struct that drives the cells.
// No dependencies.
package sil_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef logic signed [VAL_W-1:0] sil_val_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } sil_op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ELEM     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } sil_status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic     ins_en;
    logic     rot_en;
    sil_val_t ins_value;
  } sil_cell_cmd_t;

endpackage

>>> rtl/sil_if.sv
// sil_in_if / sil_out_if: valid-ready channels of the sorted insert list.
// Depends on sil_pkg for the payload types.
interface sil_in_if;
  import sil_pkg::*;
  logic     valid;
  logic     ready;
  sil_op_t  op;
  sil_val_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface sil_out_if;
  import sil_pkg::*;
  logic        valid;
  logic        ready;
  sil_status_t status;
  sil_val_t    value_res;
  logic        last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink (input valid, input status, input value_res, input last, output ready);
endinterface

>>> rtl/sil_cell.sv
// sil_cell: one slot of the sorted chain; holds a value and shifts or rotates it.
// Depends on sil_pkg for the command struct and value type.
module sil_cell
  import sil_pkg::*;
(
  input  logic          clk,
  input  sil_cell_cmd_t cmd,
  input  logic          occupied,
  input  sil_val_t      left_val,
  input  logic          left_open,
  input  sil_val_t      right_val,
  output sil_val_t      val,
  output logic          open
);

  // slot is open for the new value if empty or holding a value not smaller
  assign open = !occupied || !(val < cmd.ins_value);

  // insert: shift right from an open neighbor or take the new value; read: rotate left
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (left_open) begin
        val <= left_val;
      end else if (open) begin
        val <= cmd.ins_value;
      end
    end else if (cmd.rot_en) begin
      val <= right_val;
    end
  end

endmodule

>>> rtl/sorted_insert_list.sv
// sorted_insert_list: top level; cell chain, entry count, read-out sequencer, output register.
// Depends on sil_pkg, sil_if and sil_cell.
//
//   channel  | dir | payload                   | beat
//   in_ch    | in  | op, value                 | one op per beat
//   out_ch   | out | status, value_res, last   | one result per beat
//
// insert and clear complete when accepted; the result sits in the output register
// read-out rotates the whole chain once and holds while an element waits for the output register
// a new beat is taken only in idle with the output register free or draining
// reset clears the entry count and control; cell contents are left as they are
module sorted_insert_list
  import sil_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sil_in_if.sink    in_ch,
  sil_out_if.source out_ch
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t        state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic          out_valid;
  sil_status_t   out_status;
  sil_val_t      out_value;
  logic          out_last;

  sil_val_t      cell_val [DEPTH];
  logic [DEPTH-1:0] cell_open;
  logic [DEPTH-1:0] occupied;
  sil_cell_cmd_t cmd;

  logic acc, out_free, full, emit, step, out_load;
  logic [CNT_W-1:0] idx_ext;

  // handshake and read-out step control
  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = (count == CNT_W'(DEPTH));
  assign idx_ext     = CNT_W'(idx);
  assign emit        = (state == S_READ) && (idx_ext < count) && out_free;
  assign step        = (state == S_READ) && ((idx_ext >= count) || out_free);

  // output register gets a new beat this cycle
  assign out_load = (acc && ((in_ch.op == OP_INSERT) || (in_ch.op == OP_CLEAR) ||
                             ((in_ch.op == OP_READ) && (count == '0)))) || emit;

  // cell command
  assign cmd.ins_en    = acc && (in_ch.op == OP_INSERT) && !full;
  assign cmd.rot_en    = step;
  assign cmd.ins_value = in_ch.value;

  // chain of cells; occupancy follows from the count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      sil_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occupied  (occupied[i]),
        .left_val  (in_ch.value),
        .left_open (1'b0),
        .right_val (cell_val[(i + 1) % DEPTH]),
        .val       (cell_val[i]),
        .open      (cell_open[i])
      );
    end else begin : g_body
      sil_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occupied  (occupied[i]),
        .left_val  (cell_val[i-1]),
        .left_open (cell_open[i-1]),
        .right_val (cell_val[(i + 1) % DEPTH]),
        .val       (cell_val[i]),
        .open      (cell_open[i])
      );
    end
  end

  // sequencer, entry count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (in_ch.op)
              OP_INSERT: begin
                out_valid  <= 1'b1;
                out_status <= full ? ST_FULL : ST_INSERTED;
                out_value  <= '0;
                out_last   <= 1'b1;
                if (!full) begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_READ: begin
                if (count == '0) begin
                  out_valid  <= 1'b1;
                  out_status <= ST_EMPTY;
                  out_value  <= '0;
                  out_last   <= 1'b1;
                end else begin
                  state <= S_READ;
                  idx   <= '0;
                end
              end
              OP_CLEAR: begin
                count      <= '0;
                out_valid  <= 1'b1;
                out_status <= ST_CLEARED;
                out_value  <= '0;
                out_last   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (step) begin
            if (emit) begin
              out_valid  <= 1'b1;
              out_status <= ST_ELEM;
              out_value  <= cell_val[0];
              out_last   <= (idx_ext == count - CNT_W'(1));
            end
            if (idx == IDX_W'(DEPTH - 1)) begin
              state <= S_IDLE;
            end
            idx <= idx + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.value_res = out_value;
  assign out_ch.last      = out_last;

  // refused insert leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    acc && (in_ch.op == OP_INSERT) && full |=> count == CNT_W'(DEPTH))
    else $error("count changed on refused insert");

  // accepted insert grows the count by one
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    acc && (in_ch.op == OP_INSERT) && !full |=> count == $past(count) + CNT_W'(1))
    else $error("count not incremented on insert");

  // clear empties the table
  a_clear: assert property (@(posedge clk) disable iff (rst)
    acc && (in_ch.op == OP_CLEAR) |=> count == '0)
    else $error("count not zero after clear");

  // read-out never changes the count
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> count == $past(count))
    else $error("count changed during read-out");

  // each read-out emit loads an element result into the output register
  a_elem_src: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && (out_status == ST_ELEM))
    else $error("read-out element not loaded");

endmodule
